// File: rtl/tccc_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor controller package
// Geometry constants, field types and control structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tccc_pkg;

    // Font cell geometry in pixels
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int GAP_RIGHT    = 1;
    localparam int GAP_BOTTOM   = 2;

    localparam int CELL_W = GLYPH_WIDTH + GAP_RIGHT;
    localparam int LINE_H = GLYPH_HEIGHT + GAP_BOTTOM;

    localparam int COORD_W = 13;   // cursor and anchor coordinates
    localparam int PIX_W   = 12;   // screen size and output coordinates
    localparam int CALC_W  = 16;   // signed working width for position math

    // Cells per line: floor(width / CELL_W) by reciprocal multiply, exact
    // for every 12-bit width since the shift covers 12 + log2(CELL_W) bits.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_MULT  = ((2 ** RECIP_SHIFT) + CELL_W - 1) / CELL_W;
    localparam int PROD_W      = 30;
    localparam int QUOT_W      = 10;

    localparam logic [PIX_W-1:0]  SW_RESET = 12'd1024;
    localparam logic [PIX_W-1:0]  SH_RESET = 12'd768;
    localparam logic [QUOT_W-1:0] Q_RESET  = QUOT_W'(1024 / CELL_W);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        CMD_PUT  = 2'd0,
        CMD_BACK = 2'd1,
        CMD_MARK = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_ERASE  = 2'd1,
        OP_SCROLL = 2'd2
    } op_t;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  char_code;
        logic        glyph_present;
        logic [31:0] text_color;
    } ev_word_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel_row;
        logic [PIX_W-1:0] pixel_col;
        logic [7:0]       glyph_code;
        logic [31:0]      draw_color;
        logic             last;
    } fb_word_t;

    // Screen settings as seen by the update logic
    typedef struct packed {
        logic [PIX_W-1:0] screen_width;
        logic [PIX_W-1:0] screen_height;
        logic [PIX_W-1:0] last_cell_col;
    } cfg_t;

    // Up to two words produced by one event
    typedef struct packed {
        logic     push0;
        logic     push1;
        fb_word_t w0;
        fb_word_t w1;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/tccc_cfg.sv
// ----------------------------------------------------------------------------
// Screen settings registers
// Holds width and height, and derives the column of the last whole cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [tccc_pkg::PIX_W-1:0] cfg_data,
    output tccc_pkg::cfg_t                 cfg
);
    import tccc_pkg::*;

    logic [PIX_W-1:0]  sw_reg, sw_next;
    logic [PIX_W-1:0]  sh_reg, sh_next;
    logic [QUOT_W-1:0] cells_reg, cells_next;
    logic [PROD_W-1:0] recip_prod;
    logic [CALC_W-1:0] last_prod;

    // cells per line of the new width, taken with the write
    assign recip_prod = PROD_W'(cfg_data) * PROD_W'(RECIP_MULT);

    always_comb
    begin
        sw_next    = sw_reg;
        sh_next    = sh_reg;
        cells_next = cells_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:
                begin
                    sw_next    = cfg_data;
                    cells_next = recip_prod[RECIP_SHIFT +: QUOT_W];
                end
                REG_SCREEN_HEIGHT:
                begin
                    sh_next = cfg_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= SW_RESET;
            sh_reg    <= SH_RESET;
            cells_reg <= Q_RESET;
        end
        else
        begin
            sw_reg    <= sw_next;
            sh_reg    <= sh_next;
            cells_reg <= cells_next;
        end
    end

    assign last_prod = CALC_W'(cells_reg - QUOT_W'(1)) * CALC_W'(CELL_W);

    always_comb
    begin
        cfg.screen_width  = sw_reg;
        cfg.screen_height = sh_reg;
        // screen narrower than one cell: saturate to column zero
        cfg.last_cell_col = (cells_reg == '0) ? '0 : last_prod[PIX_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/tccc_core.sv
// ----------------------------------------------------------------------------
// Cursor update stage
// Registers one event, works out its commands and the new cursor and anchor.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               ev_valid,
    output logic                    ev_stall,
    input  wire tccc_pkg::ev_word_t ev_data,
    input  wire tccc_pkg::cfg_t     cfg,
    input  wire logic               room,
    output tccc_pkg::res_t          res
);
    import tccc_pkg::*;

    localparam logic signed [CALC_W-1:0] CELL_S = CALC_W'(CELL_W);
    localparam logic signed [CALC_W-1:0] LINE_S = CALC_W'(LINE_H);

    logic                     in_valid_reg, in_valid_next;
    ev_word_t                 in_reg;
    logic                     accept;
    logic                     fire;

    logic [COORD_W-1:0]       cur_row_reg, cur_row_next;
    logic [COORD_W-1:0]       cur_col_reg, cur_col_next;
    logic [COORD_W-1:0]       anc_row_reg, anc_row_next;
    logic [COORD_W-1:0]       anc_col_reg, anc_col_next;

    logic signed [CALC_W-1:0] row0, col0, arow0, acol0;
    logic signed [CALC_W-1:0] sw_s, sh_s;
    logic signed [CALC_W-1:0] col_adv, col1, row1, row2, arow_up;
    logic signed [CALC_W-1:0] col_bk, row_bk_raw, row_bk, col_bk_fix;
    logic                     is_nl, draw, wrap, scroll, blocked, under;
    fb_word_t                 draw_w, scroll_w, erase_w;

    assign fire     = in_valid_reg && room;
    assign ev_stall = in_valid_reg && !fire;
    assign accept   = ev_valid && !ev_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= ev_data;
    end

    // position math on signed working copies
    always_comb
    begin
        row0  = $signed(CALC_W'(cur_row_reg));
        col0  = $signed(CALC_W'(cur_col_reg));
        arow0 = $signed(CALC_W'(anc_row_reg));
        acol0 = $signed(CALC_W'(anc_col_reg));
        sw_s  = $signed(CALC_W'(cfg.screen_width));
        sh_s  = $signed(CALC_W'(cfg.screen_height));

        // put character / newline
        is_nl   = (in_reg.char_code == NEWLINE_CODE);
        draw    = !is_nl && in_reg.glyph_present;
        col_adv = col0 + CELL_S;
        wrap    = is_nl || (col_adv >= sw_s);
        col1    = wrap ? '0 : col_adv;
        row1    = wrap ? row0 + LINE_S : row0;
        scroll  = (row1 + LINE_S) >= sh_s;
        row2    = scroll ? row1 - LINE_S : row1;
        arow_up = arow0 - LINE_S;

        // backspace
        col_bk     = col0 - CELL_S;
        blocked    = (acol0 > col_bk) && (arow0 >= row0);
        under      = col_bk < 0;
        row_bk_raw = row0 - LINE_S;
        if (!under)
            row_bk = row0;
        else if (row_bk_raw < 0)
            row_bk = '0;
        else
            row_bk = row_bk_raw;
        col_bk_fix = under ? $signed(CALC_W'(cfg.last_cell_col)) : col_bk;
    end

    always_comb
    begin
        draw_w.op         = OP_DRAW;
        draw_w.pixel_row  = row0[PIX_W-1:0];
        draw_w.pixel_col  = col0[PIX_W-1:0];
        draw_w.glyph_code = in_reg.char_code;
        draw_w.draw_color = in_reg.text_color;
        draw_w.last       = !scroll;

        scroll_w.op         = OP_SCROLL;
        scroll_w.pixel_row  = '0;
        scroll_w.pixel_col  = '0;
        scroll_w.glyph_code = '0;
        scroll_w.draw_color = '0;
        scroll_w.last       = 1'b1;

        erase_w.op         = OP_ERASE;
        erase_w.pixel_row  = row_bk[PIX_W-1:0];
        erase_w.pixel_col  = col_bk_fix[PIX_W-1:0];
        erase_w.glyph_code = '0;
        erase_w.draw_color = '0;
        erase_w.last       = 1'b1;
    end

    always_comb
    begin
        res.push0    = 1'b0;
        res.push1    = 1'b0;
        res.w0       = scroll_w;
        res.w1       = scroll_w;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        anc_row_next = anc_row_reg;
        anc_col_next = anc_col_reg;
        if (fire)
        begin
            unique case (in_reg.cmd)
                CMD_PUT:
                begin
                    cur_row_next = row2[COORD_W-1:0];
                    cur_col_next = col1[COORD_W-1:0];
                    if (scroll)
                    begin
                        // anchor leaving the top clears to the origin
                        if (arow_up < 0)
                        begin
                            anc_row_next = '0;
                            anc_col_next = '0;
                        end
                        else
                        begin
                            anc_row_next = arow_up[COORD_W-1:0];
                        end
                    end
                    if (draw)
                    begin
                        res.push0 = 1'b1;
                        res.w0    = draw_w;
                        res.push1 = scroll;
                    end
                    else
                    begin
                        res.push0 = scroll;
                    end
                end
                CMD_BACK:
                begin
                    if (!blocked)
                    begin
                        cur_row_next = row_bk[COORD_W-1:0];
                        cur_col_next = col_bk_fix[COORD_W-1:0];
                        res.push0    = 1'b1;
                        res.w0       = erase_w;
                    end
                end
                CMD_MARK:
                begin
                    anc_row_next = cur_row_reg;
                    anc_col_next = cur_col_reg;
                end
                default:
                begin
                    // unused code: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            anc_row_reg <= '0;
            anc_col_reg <= '0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            anc_row_reg <= anc_row_next;
            anc_col_reg <= anc_col_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tccc_outq.sv
// ----------------------------------------------------------------------------
// Command output buffer
// Output register plus one pending slot for the second word of an event.
// ----------------------------------------------------------------------------
`default_nettype none

module tccc_outq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tccc_pkg::res_t res,
    output logic                room,
    output logic                fb_valid,
    input  wire logic           fb_stall,
    output tccc_pkg::fb_word_t  fb_data
);
    import tccc_pkg::*;

    logic     out_valid_reg, out_valid_next;
    fb_word_t out_reg, out_next;
    logic     pend_valid_reg, pend_valid_next;
    fb_word_t pend_reg, pend_next;
    logic     taken;

    assign taken = out_valid_reg && !fb_stall;
    assign room  = !pend_valid_reg && (!out_valid_reg || !fb_stall);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (res.push0)
        begin
            out_valid_next  = 1'b1;
            out_next        = res.w0;
            pend_valid_next = res.push1;
            pend_next       = res.w1;
        end
        else if (taken || !out_valid_reg)
        begin
            // advance the pending word
            out_valid_next  = pend_valid_reg;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign fb_valid = out_valid_reg;
    assign fb_data  = out_reg;

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending word without an output word");

    a_pend_closes: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_reg.last)
        else $error("pending word does not close its event");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        res.push1 |-> (res.push0 && !res.w0.last && room))
        else $error("second word pushed out of order or without room");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.push0 |-> room)
        else $error("word pushed while buffer full");

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_controller_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor controller
// Tracks a pixel cursor and input anchor and issues draw, erase and scroll
// commands to a framebuffer engine.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   ev        in         ev_valid / ev_stall   ev_data   (tccc_pkg::ev_word_t)
//   fb        out        fb_valid / fb_stall   fb_data   (tccc_pkg::fb_word_t)
//   cfg       in         cfg_we                cfg_index, cfg_data
//
// An event is held in the input register and its first command is registered
// in the output register once the buffer has room. One event per cycle is
// taken when it yields at most one command and fb does not stall; an event
// yielding a draw and a scroll holds the update stage while the pending slot
// drains. Reset clears cursor and anchor to the origin and loads a 1024 x 768
// screen. A stalled fb channel holds its word; ev stalls while the input
// register holds an event that the output buffer cannot take yet.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_controller_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       ev_valid,
    output logic                            ev_stall,
    input  wire tccc_pkg::ev_word_t         ev_data,
    output logic                            fb_valid,
    input  wire logic                       fb_stall,
    output tccc_pkg::fb_word_t              fb_data,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [tccc_pkg::PIX_W-1:0] cfg_data
);
    import tccc_pkg::*;

    cfg_t cfg;
    res_t res;
    logic room;

    tccc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tccc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev_stall (ev_stall),
        .ev_data  (ev_data),
        .cfg      (cfg),
        .room     (room),
        .res      (res)
    );

    tccc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .room     (room),
        .fb_valid (fb_valid),
        .fb_stall (fb_stall),
        .fb_data  (fb_data)
    );

endmodule

`default_nettype wire

// File: tb/tb_text_console_cursor_controller_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor controller testbench
// Drives console events and screen-size writes into the block, keeps its own
// cursor and anchor to predict every draw, erase and scroll word, and checks
// each word leaving the fb channel against the oldest prediction in order.
// ----------------------------------------------------------------------------

// Predicts framebuffer commands from accepted events and matches them in order
class fb_cmd_board;
    int             scr_w;
    int             scr_h;
    int             cur_row;
    int             cur_col;
    int             anc_row;
    int             anc_col;
    tccc_pkg::fb_word_t pending_cmds[$];
    int unsigned    errors;
    int unsigned    n_draw;
    int unsigned    n_erase;
    int unsigned    n_scroll;

    function new();
        scr_w    = 1024;
        scr_h    = 768;
        cur_row  = 0;
        cur_col  = 0;
        anc_row  = 0;
        anc_col  = 0;
        errors   = 0;
        n_draw   = 0;
        n_erase  = 0;
        n_scroll = 0;
    endfunction

    function void set_reg(tccc_pkg::cfg_reg_t idx, logic [tccc_pkg::PIX_W-1:0] val);
        if (idx == tccc_pkg::REG_SCREEN_WIDTH)
            scr_w = int'(val);
        else
            scr_h = int'(val);
    endfunction

    function void push_cmd(tccc_pkg::op_t op, int row, int col, logic [7:0] code,
                           logic [31:0] color);
        tccc_pkg::fb_word_t w;
        w.op         = op;
        w.pixel_row  = tccc_pkg::PIX_W'(row);
        w.pixel_col  = tccc_pkg::PIX_W'(col);
        w.glyph_code = code;
        w.draw_color = color;
        w.last       = 1'b0;
        pending_cmds.push_back(w);
    endfunction

    // Advance the cursor for one accepted event and queue the words it causes
    function void take_event(tccc_pkg::ev_word_t ev);
        int row;
        int col;
        int arow;
        int base;
        base = pending_cmds.size();
        row  = cur_row;
        col  = cur_col;
        case (ev.cmd)
            tccc_pkg::CMD_PUT:
            begin
                if (ev.char_code == tccc_pkg::NEWLINE_CODE)
                begin
                    col = 0;
                    row += tccc_pkg::LINE_H;
                end
                else
                begin
                    if (ev.glyph_present)
                        push_cmd(tccc_pkg::OP_DRAW, row, col, ev.char_code, ev.text_color);
                    col += tccc_pkg::CELL_W;
                    if (col >= scr_w)
                    begin
                        col = 0;
                        row += tccc_pkg::LINE_H;
                    end
                end
                // one scroll at most, even if the line still hits the bottom
                if (row + tccc_pkg::LINE_H >= scr_h)
                begin
                    push_cmd(tccc_pkg::OP_SCROLL, 0, 0, 8'd0, 32'd0);
                    row -= tccc_pkg::LINE_H;
                    arow = anc_row - tccc_pkg::LINE_H;
                    if (arow < 0)
                    begin
                        anc_row = 0;
                        anc_col = 0;
                    end
                    else
                        anc_row = arow & 32'h1FFF;
                end
            end
            tccc_pkg::CMD_BACK:
            begin
                col -= tccc_pkg::CELL_W;
                // stop at the anchor
                if (anc_col > col && anc_row >= row)
                    return;
                if (col < 0)
                begin
                    row -= tccc_pkg::LINE_H;
                    if (row < 0)
                        row = 0;
                    col = (scr_w / tccc_pkg::CELL_W - 1) * tccc_pkg::CELL_W;
                    if (col < 0)
                        col = 0;
                end
                push_cmd(tccc_pkg::OP_ERASE, row, col, 8'd0, 32'd0);
            end
            tccc_pkg::CMD_MARK:
            begin
                anc_row = row;
                anc_col = col;
                return;
            end
            default:
                return;
        endcase
        cur_row = row & 32'h1FFF;
        cur_col = col & 32'h1FFF;
        if (pending_cmds.size() > base)
            pending_cmds[pending_cmds.size()-1].last = 1'b1;
    endfunction

    function void match_word(tccc_pkg::fb_word_t got);
        tccc_pkg::fb_word_t want;
        if (pending_cmds.size() == 0)
        begin
            $display("%0t: unexpected word: expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_cmds.pop_front();
        case (want.op)
            tccc_pkg::OP_DRAW:  n_draw++;
            tccc_pkg::OP_ERASE: n_erase++;
            default:            n_scroll++;
        endcase
        if (got.op !== want.op)
        begin
            $display("%0t: op: expected %0d, actual %0d", $time, want.op, got.op);
            errors++;
        end
        if (got.pixel_row !== want.pixel_row)
        begin
            $display("%0t: pixel_row: expected %0d, actual %0d", $time, want.pixel_row,
                     got.pixel_row);
            errors++;
        end
        if (got.pixel_col !== want.pixel_col)
        begin
            $display("%0t: pixel_col: expected %0d, actual %0d", $time, want.pixel_col,
                     got.pixel_col);
            errors++;
        end
        if (got.glyph_code !== want.glyph_code)
        begin
            $display("%0t: glyph_code: expected %h, actual %h", $time, want.glyph_code,
                     got.glyph_code);
            errors++;
        end
        if (got.draw_color !== want.draw_color)
        begin
            $display("%0t: draw_color: expected %h, actual %h", $time, want.draw_color,
                     got.draw_color);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last: expected %b, actual %b", $time, want.last, got.last);
            errors++;
        end
    endfunction

    function int unsigned outstanding();
        return pending_cmds.size();
    endfunction
endclass

module tb_text_console_cursor_controller_unit;
    import tccc_pkg::*;

    localparam int    CYCLE_LIMIT  = 800000;
    localparam int    SETTLE_TICKS = 8;
    localparam int    PHASES       = 13;
    localparam int    PHASE_EVENTS = 100;
    localparam cmd_t  CMD_UNUSED   = cmd_t'(2'd3);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 ev_valid  = 1'b0;
    logic                 ev_stall;
    ev_word_t             ev_data   = '0;
    logic                 fb_valid;
    logic                 fb_stall  = 1'b0;
    fb_word_t             fb_data;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [PIX_W-1:0]     cfg_data  = '0;

    fb_cmd_board          board = new();
    bit                   calm = 1'b0;
    int unsigned          events_sent = 0;
    int unsigned          settings_used = 1;
    int unsigned          cycles = 0;
    int unsigned          stall_left = 0;

    text_console_cursor_controller_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_stall  (ev_stall),
        .ev_data   (ev_data),
        .fb_valid  (fb_valid),
        .fb_stall  (fb_stall),
        .fb_data   (fb_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk)
    begin : fb_stall_gen
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n || calm)
        begin
            stall_left = 0;
            fb_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            fb_stall <= 1'b1;
        end
        else if (r < 25)
            fb_stall <= 1'b1;
        else if (r < 27)
        begin
            stall_left = $urandom_range(8, 40);
            fb_stall <= 1'b1;
        end
        else
            fb_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && fb_valid && !fb_stall)
            board.match_word(fb_data);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic ev_word_t make_ev(cmd_t c, logic [7:0] code, logic present,
                                         logic [31:0] color);
        ev_word_t ev;
        ev.cmd           = c;
        ev.char_code     = code;
        ev.glyph_present = present;
        ev.text_color    = color;
        return ev;
    endfunction

    function automatic ev_word_t random_ev();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return make_ev(CMD_PUT, 8'($urandom), $urandom_range(0, 9) != 0, $urandom);
        if (r < 67)
            return make_ev(CMD_PUT, NEWLINE_CODE, 1'($urandom), $urandom);
        if (r < 85)
            return make_ev(CMD_BACK, 8'($urandom), 1'($urandom), $urandom);
        if (r < 95)
            return make_ev(CMD_MARK, 8'($urandom), 1'($urandom), $urandom);
        return make_ev(CMD_UNUSED, 8'($urandom), 1'($urandom), $urandom);
    endfunction

    function automatic logic [PIX_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 12'd1;
            1:       return 12'd4095;
            2, 3:    return PIX_W'($urandom_range(2, 60));
            4, 5, 6: return PIX_W'($urandom_range(61, 600));
            default: return PIX_W'($urandom_range(601, 4094));
        endcase
    endfunction

    task automatic send_event(ev_word_t ev);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            ev_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_data  <= ev;
        do
            @(posedge clk);
        while (ev_stall);
        board.take_event(ev);
        if (ev.cmd != CMD_UNUSED)
            events_sent++;
    endtask

    // Drop valid, wait out every predicted word, then let the block settle
    task automatic hold_until_drained();
        ev_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [PIX_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_screen(logic [PIX_W-1:0] w, logic [PIX_W-1:0] h);
        hold_until_drained();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int p;
        int r;
        int unsigned goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default 1024 x 768 screen: draws, missing glyph, erase, anchor stop
        send_event(make_ev(CMD_PUT, 8'h41, 1'b1, 32'hFFFF_FFFF));
        send_event(make_ev(CMD_PUT, 8'hFF, 1'b1, 32'h0000_0000));
        send_event(make_ev(CMD_PUT, 8'h00, 1'b0, 32'h1234_5678));
        send_event(make_ev(CMD_BACK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_MARK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_BACK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_PUT, NEWLINE_CODE, 1'b1, 32'hDEAD_BEEF));
        // back past column zero wraps to the last cell of the line above
        send_event(make_ev(CMD_BACK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF));
        send_event(make_ev(CMD_PUT, 8'hAA, 1'b1, 32'hA5A5_A5A5));
        send_event(make_ev(CMD_PUT, 8'h55, 1'b1, 32'h5A5A_5A5A));

        // screen narrower than a cell
        set_screen(12'd1, 12'd4095);
        send_event(make_ev(CMD_PUT, 8'h78, 1'b1, 32'h00FF_00FF));
        send_event(make_ev(CMD_BACK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_MARK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_BACK, 8'h00, 1'b0, 32'h0));

        // one-pixel-high screen: every line change scrolls, draw then scroll
        set_screen(12'd4095, 12'd1);
        send_event(make_ev(CMD_PUT, NEWLINE_CODE, 1'b0, 32'h0));
        send_event(make_ev(CMD_PUT, NEWLINE_CODE, 1'b0, 32'h0));
        send_event(make_ev(CMD_PUT, 8'h7E, 1'b1, 32'hFF00_FF00));

        // zero screen size
        set_screen(12'd0, 12'd0);
        send_event(make_ev(CMD_PUT, 8'h81, 1'b1, 32'h8000_0001));
        send_event(make_ev(CMD_BACK, 8'h00, 1'b0, 32'h0));
        send_event(make_ev(CMD_PUT, NEWLINE_CODE, 1'b1, 32'h0));

        // anchor scrolled off the top returns to the origin
        set_screen(12'd1024, 12'd100);
        send_event(make_ev(CMD_MARK, 8'h00, 1'b0, 32'h0));
        repeat (5) send_event(make_ev(CMD_PUT, NEWLINE_CODE, 1'b0, 32'h0));

        for (p = 0; p < PHASES; p++)
        begin
            hold_until_drained();
            r = $urandom_range(0, 3);
            if (r != 1)
                write_reg(REG_SCREEN_WIDTH, pick_dim());
            if (r != 2)
                write_reg(REG_SCREEN_HEIGHT, pick_dim());
            settings_used++;
            calm = (p % 4 == 1);
            goal = events_sent + PHASE_EVENTS;
            while (events_sent < goal)
            begin
                if ($urandom_range(0, 199) == 0)
                    hold_until_drained();
                send_event(random_ev());
            end
        end
        calm = 1'b0;

        ev_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Ran %0d console events over %0d screen settings.",
                 events_sent, settings_used);
        $display("Matched %0d draws, %0d erases and %0d scrolls.",
                 board.n_draw, board.n_erase, board.n_scroll);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
rtl/tccc_pkg.sv
rtl/tccc_cfg.sv
rtl/tccc_core.sv
rtl/tccc_outq.sv
rtl/text_console_cursor_controller_unit.sv
tb/tb_text_console_cursor_controller_unit.sv
